@@ hw/rtl/bsfc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsfc_pkg
// Shared types and constants for the biosignal sample filter chain.
// ----------------------------------------------------------------------------
`default_nettype none

package bsfc_pkg;

    localparam int SAMPLE_W = 24;
    localparam int CH_FIELD_W = 2;
    localparam int COEF_W = 16;
    localparam int GAIN_W = 10;
    localparam int PH_W = 16;
    localparam int X_W = 32;
    localparam int HP_W = 40;
    localparam int PLOT_W = 32;
    localparam int POS_W = 10;
    localparam int HW_CH = 3;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FIFO_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HP_COEF_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HP_COEF_CH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HP_COEF_CH2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PLOT_HEIGHT = 3'd6;

    localparam logic [COEF_W-1:0] HP_COEF_CH0_RST = 16'd61662;
    localparam logic [COEF_W-1:0] HP_COEF_CH1_RST = 16'd63540;
    localparam logic [COEF_W-1:0] HP_COEF_CH2_RST = 16'd63540;
    localparam logic [GAIN_W-1:0] GAIN_CH0_RST = 10'd500;
    localparam logic [GAIN_W-1:0] GAIN_CH1_RST = 10'd200;
    localparam logic [GAIN_W-1:0] GAIN_CH2_RST = 10'd200;
    localparam logic [PH_W-1:0] PLOT_HEIGHT_RST = 16'd512;

    localparam logic [PLOT_W-1:0] PLOT_MAX = 32'h7FFF_FFFF;
    localparam logic [PLOT_W-1:0] PLOT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [7:0] byte_high;
        logic [7:0] byte_mid;
        logic [7:0] byte_low;
        logic [CH_FIELD_W-1:0] channel;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw_sample;
        logic signed [PLOT_W-1:0] plot_value;
        logic [POS_W-1:0] plot_position;
    } out_item_t;

    typedef struct packed {
        logic [HW_CH-1:0][COEF_W-1:0] hp_coef;
        logic [HW_CH-1:0][GAIN_W-1:0] gain;
        logic [PH_W-1:0] plot_height;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] raw;
        logic [CH_FIELD_W-1:0] ch;
        logic active;
        logic signed [X_W-1:0] x;
    } q_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/bsfc_front.sv @@
// ----------------------------------------------------------------------------
// bsfc_front
// Input word register, channel check and Q.16 input scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfc_front
    import bsfc_pkg::*;
#(
    parameter int NCH
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    input  wire logic [PH_W-1:0] plot_height,
    input  wire q_stat_t  q_stat,
    output logic          push,
    output q_item_t       push_item
);

    logic     item_valid_reg;
    logic     item_valid_next;
    in_item_t item_reg;
    logic     accept;
    logic signed [SAMPLE_W-1:0] raw;
    logic signed [SAMPLE_W+PH_W:0] scaled;

    assign in_stall = item_valid_reg && q_stat.full;
    assign accept   = in_valid && !in_stall;
    assign push     = item_valid_reg && !q_stat.full;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
        begin
            item_valid_next = 1'b1;
        end
        else if (push)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
        end
    end

    // x = floor(sample * plot_height / 2^8)
    assign raw    = $signed({item_reg.byte_high, item_reg.byte_mid, item_reg.byte_low});
    assign scaled = raw * $signed({1'b0, plot_height});

    always_comb
    begin
        push_item.raw    = raw;
        push_item.ch     = item_reg.channel;
        push_item.active = ({1'b0, item_reg.channel} < (CH_FIELD_W+1)'(NCH));
        push_item.x      = $signed(scaled[X_W+7:8]);
    end

endmodule

`default_nettype wire

@@ hw/rtl/bsfc_fifo.sv @@
// ----------------------------------------------------------------------------
// bsfc_fifo
// Short word queue between the front and the filter sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfc_fifo
    import bsfc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire q_item_t push_item,
    input  wire logic    pop,
    output q_item_t      pop_item,
    output q_stat_t      q_stat
);

    localparam int FP_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FC_W = $clog2(FIFO_DEPTH + 1);

    q_item_t         entry_reg [FIFO_DEPTH];
    logic [FP_W-1:0] wr_ptr_reg;
    logic [FP_W-1:0] wr_ptr_next;
    logic [FP_W-1:0] rd_ptr_reg;
    logic [FP_W-1:0] rd_ptr_next;
    logic [FC_W-1:0] count_reg;
    logic [FC_W-1:0] count_next;

    assign q_stat.full  = (count_reg == FC_W'(FIFO_DEPTH));
    assign q_stat.empty = (count_reg == '0);
    assign pop_item     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FP_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FP_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/bsfc_back.sv @@
// ----------------------------------------------------------------------------
// bsfc_back
// Filter sequencer: high-pass, boxcar average, divide, gain, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bsfc_back
    import bsfc_pkg::*;
#(
    parameter int NCH,
    parameter int AVG_DEPTH,
    parameter int AVG_TAPS,
    parameter int PLOT_DEPTH
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire cfg_t    cfg,
    input  wire q_stat_t q_stat,
    input  wire q_item_t pop_item,
    output logic         pop,
    output logic         out_valid,
    input  wire logic    out_stall,
    output out_item_t    out_data
);

    localparam int CH_W = (NCH > 1) ? $clog2(NCH) : 1;
    localparam int AI_W = $clog2(AVG_DEPTH);
    localparam int PI_W = $clog2(PLOT_DEPTH);
    localparam int MEM_D = NCH * AVG_DEPTH;
    localparam int MA_W = $clog2(MEM_D);
    localparam int KMUL = AVG_TAPS / AVG_DEPTH;
    localparam int RSTEP = AVG_TAPS % AVG_DEPTH;
    localparam int SPAN = (AVG_TAPS > AVG_DEPTH) ? AVG_TAPS : AVG_DEPTH;
    localparam int SUM_W = HP_W + $clog2(SPAN) + 1;
    localparam int T_W = HP_W + 2;
    localparam int P_W = T_W + COEF_W + 1;
    localparam int SH_W = P_W - 16;
    localparam int DIV_BITS = 8;
    localparam int DIV_STEPS = (SUM_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_W = DIV_STEPS * DIV_BITS;
    localparam int DC_W = $clog2(DIV_STEPS + 1);
    localparam int REM_W = $clog2(AVG_DEPTH);
    localparam int A_W = SUM_W + 1;
    localparam int M_W = A_W + GAIN_W + 1;
    localparam int V_W = M_W + 1;
    localparam int VQ_W = V_W - 16;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_DIFF  = 8'b0000_0010,
        ST_MUL   = 8'b0000_0100,
        ST_UPD   = 8'b0000_1000,
        ST_SUM   = 8'b0001_0000,
        ST_DIV   = 8'b0010_0000,
        ST_SCALE = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } bstate_t;

    bstate_t state_reg;
    bstate_t state_next;

    q_item_t cur_reg;
    logic [CH_W-1:0] ci;

    logic signed [X_W-1:0]   prev_in_reg  [NCH];
    logic signed [HP_W-1:0]  prev_out_reg [NCH];
    logic signed [SUM_W-1:0] total_reg    [NCH];
    logic signed [SUM_W-1:0] part_reg     [NCH];
    logic [AI_W-1:0]         avg_idx_reg  [NCH];
    logic [PI_W-1:0]         plot_idx_reg [NCH];

    logic signed [HP_W-1:0] win_mem [MEM_D];
    logic [MEM_D-1:0]       win_valid_reg;
    logic signed [HP_W-1:0] rd_near_reg;
    logic signed [HP_W-1:0] rd_far_reg;
    logic [MA_W-1:0]        addr_near_reg;
    logic [MA_W-1:0]        addr_near;
    logic [MA_W-1:0]        addr_far;
    logic [MA_W-1:0]        addr_base;
    logic [AI_W:0]          far_sum;
    logic [AI_W-1:0]        far_pos;

    logic signed [T_W-1:0] t_reg;
    logic signed [P_W-1:0] prod_reg;
    logic [AI_W-1:0]       pos_reg;
    logic [AI_W-1:0]       pos_dec;

    logic signed [SH_W-1:0] sh;
    logic signed [HP_W-1:0] y;

    logic signed [SUM_W-1:0] sum_w;
    logic [SUM_W-1:0]        mag;
    logic                    neg_reg;
    logic [DIV_W-1:0]        div_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [DC_W-1:0]         div_cnt_reg;
    logic [DC_W-1:0]         div_cnt_next;
    logic [DIV_W-1:0]        dv_step;
    logic [REM_W-1:0]        rem_step;

    logic signed [A_W-1:0] avg;
    logic signed [M_W-1:0] mprod_reg;
    logic signed [V_W-1:0] v;
    logic signed [VQ_W-1:0] vq;
    logic [PLOT_W-1:0]     plot_sat;
    logic [PI_W-1:0]       pp_dec;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    logic      out_free;
    logic      out_load;

    assign ci        = cur_reg.ch[CH_W-1:0];
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = (state_reg == ST_FIN) && out_free;
    assign pop       = (state_reg == ST_IDLE) && !q_stat.empty;

    assign pos_dec = (avg_idx_reg[ci] == '0) ? AI_W'(AVG_DEPTH - 1) : avg_idx_reg[ci] - 1'b1;
    assign pp_dec  = (plot_idx_reg[ci] == '0) ? PI_W'(PLOT_DEPTH - 1) : plot_idx_reg[ci] - 1'b1;

    assign addr_base = MA_W'(MA_W'(ci) * MA_W'(AVG_DEPTH));
    assign far_sum   = (AI_W+1)'(pos_reg) + (AI_W+1)'(RSTEP);
    assign far_pos   = (far_sum >= (AI_W+1)'(AVG_DEPTH)) ?
                       AI_W'(far_sum - (AI_W+1)'(AVG_DEPTH)) : far_sum[AI_W-1:0];
    assign addr_near = addr_base + MA_W'(pos_reg);
    assign addr_far  = addr_base + MA_W'(far_pos);

    // high-pass output, floor shift and 40-bit saturation
    always_comb
    begin
        sh = $signed(prod_reg[P_W-1:16]);
        if ((sh[SH_W-1:HP_W-1] == '0) || (sh[SH_W-1:HP_W-1] == '1))
        begin
            y = sh[HP_W-1:0];
        end
        else if (sh[SH_W-1])
        begin
            y = {1'b1, {(HP_W-1){1'b0}}};
        end
        else
        begin
            y = {1'b0, {(HP_W-1){1'b1}}};
        end
    end

    assign sum_w = SUM_W'(KMUL) * total_reg[ci] + part_reg[ci];
    assign mag   = sum_w[SUM_W-1] ? SUM_W'(-sum_w) : SUM_W'(sum_w);

    // restoring divide by AVG_DEPTH, DIV_BITS quotient bits per cycle
    always_comb
    begin
        logic [REM_W:0] trial;
        logic [DIV_W-1:0] dv;
        logic [REM_W-1:0] rm;
        dv = div_reg;
        rm = rem_reg;
        for (int j = 0; j < DIV_BITS; j++)
        begin
            trial = {rm, dv[DIV_W-1]};
            if (trial >= (REM_W+1)'(AVG_DEPTH))
            begin
                rm = REM_W'(trial - (REM_W+1)'(AVG_DEPTH));
                dv = {dv[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rm = trial[REM_W-1:0];
                dv = {dv[DIV_W-2:0], 1'b0};
            end
        end
        dv_step  = dv;
        rem_step = rm;
    end

    assign avg = neg_reg ? -$signed({1'b0, div_reg[SUM_W-1:0]})
                         : $signed({1'b0, div_reg[SUM_W-1:0]});

    // output: add half the plot height, truncate toward zero, saturate to 32 bits
    always_comb
    begin
        v  = V_W'(mprod_reg) + V_W'($signed({1'b0, cfg.plot_height[PH_W-1:1], 16'h0000}));
        vq = $signed(v[V_W-1:16]);
        if (v[V_W-1] && (v[15:0] != '0))
        begin
            vq = vq + 1'b1;
        end
        if ((vq[VQ_W-1:PLOT_W-1] == '0) || (vq[VQ_W-1:PLOT_W-1] == '1))
        begin
            plot_sat = vq[PLOT_W-1:0];
        end
        else if (vq[VQ_W-1])
        begin
            plot_sat = PLOT_MIN;
        end
        else
        begin
            plot_sat = PLOT_MAX;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = pop_item.active ? ST_DIFF : ST_FIN;
                end
            end
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_UPD;
            ST_UPD:   state_next = ST_SUM;
            ST_SUM:
            begin
                state_next   = ST_DIV;
                div_cnt_next = '0;
            end
            ST_DIV:
            begin
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DC_W'(DIV_STEPS - 1))
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: state_next = ST_FIN;
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            win_valid_reg <= '0;
            for (int c = 0; c < NCH; c++)
            begin
                prev_in_reg[c]  <= '0;
                prev_out_reg[c] <= '0;
                total_reg[c]    <= '0;
                part_reg[c]     <= '0;
                avg_idx_reg[c]  <= '0;
                plot_idx_reg[c] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (state_reg == ST_UPD)
            begin
                win_valid_reg[addr_near_reg] <= 1'b1;
                prev_in_reg[ci]  <= cur_reg.x;
                prev_out_reg[ci] <= y;
                avg_idx_reg[ci]  <= pos_reg;
                total_reg[ci]    <= total_reg[ci] - SUM_W'(rd_near_reg) + SUM_W'(y);
                if (RSTEP != 0)
                begin
                    part_reg[ci] <= part_reg[ci] - SUM_W'(rd_far_reg) + SUM_W'(y);
                end
            end
            if (out_load && cur_reg.active)
            begin
                plot_idx_reg[ci] <= pp_dec;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= pop_item;
        end
        if (state_reg == ST_DIFF)
        begin
            t_reg   <= T_W'(cur_reg.x) - T_W'(prev_in_reg[ci]) + T_W'(prev_out_reg[ci]);
            pos_reg <= pos_dec;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg      <= t_reg * $signed({1'b0, cfg.hp_coef[ci]});
            addr_near_reg <= addr_near;
            rd_near_reg   <= win_valid_reg[addr_near] ? win_mem[addr_near] : '0;
            rd_far_reg    <= win_valid_reg[addr_far] ? win_mem[addr_far] : '0;
        end
        if (state_reg == ST_UPD)
        begin
            win_mem[addr_near_reg] <= y;
        end
        if (state_reg == ST_SUM)
        begin
            neg_reg <= sum_w[SUM_W-1];
            div_reg <= DIV_W'(mag);
            rem_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            div_reg <= dv_step;
            rem_reg <= rem_step;
        end
        if (state_reg == ST_SCALE)
        begin
            mprod_reg <= avg * $signed({1'b0, cfg.gain[ci]});
        end
        if (out_load)
        begin
            out_item_reg.raw_sample    <= cur_reg.raw;
            out_item_reg.plot_value    <= cur_reg.active ? $signed(plot_sat) : '0;
            out_item_reg.plot_position <= cur_reg.active ? POS_W'(pp_dec) : '0;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("pop from empty queue");

    a_pop_starts: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != ST_IDLE))
        else $error("popped word not started");

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (div_cnt_reg < DC_W'(DIV_STEPS)))
        else $error("divider step count out of range");

    a_fin_loads: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> out_valid_reg)
        else $error("result not presented");

    a_avg_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (AI_W+1)'(avg_idx_reg[0]) < (AI_W+1)'(AVG_DEPTH))
        else $error("average index out of range");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/biosignal_sample_filter_chain_top.sv @@
// ----------------------------------------------------------------------------
// biosignal_sample_filter_chain_top
// Per-channel high-pass and boxcar filter for 24-bit converter samples.
//
//   channel  dir  handshake          payload
//   in       in   in_valid/in_stall  in_data   (in_item_t)
//   out      out  out_valid/out_stall out_data (out_item_t)
//   cfg      in   cfg_we             cfg_index, cfg_data
//
// Active channel word, sequencer steps: difference, multiply, update, sum, the
// 8-bit-per-cycle divider, scale, output register. Unused channel: output only.
// Words are worked one at a time; the front and a 2-word queue take new words
// meanwhile. Reset clears all filter state at once (window valid bits).
// A stalled output holds the sequencer in its last step.
// ----------------------------------------------------------------------------
`default_nettype none

module biosignal_sample_filter_chain_top
    import bsfc_pkg::*;
#(
    parameter int AVG_DEPTH = 20,
    parameter int AVG_TAPS = 20,
    parameter int PLOT_DEPTH = 1024,
    parameter int CHANNELS = 3
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NCH = (CHANNELS < HW_CH) ? CHANNELS : HW_CH;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    q_stat_t q_stat;
    logic    push;
    q_item_t push_item;
    logic    pop;
    q_item_t pop_item;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_HP_COEF_CH0: cfg_next.hp_coef[0] = cfg_data;
                REG_HP_COEF_CH1: cfg_next.hp_coef[1] = cfg_data;
                REG_HP_COEF_CH2: cfg_next.hp_coef[2] = cfg_data;
                REG_GAIN_CH0:    cfg_next.gain[0] = cfg_data[GAIN_W-1:0];
                REG_GAIN_CH1:    cfg_next.gain[1] = cfg_data[GAIN_W-1:0];
                REG_GAIN_CH2:    cfg_next.gain[2] = cfg_data[GAIN_W-1:0];
                REG_PLOT_HEIGHT: cfg_next.plot_height = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hp_coef[0]  <= HP_COEF_CH0_RST;
            cfg_reg.hp_coef[1]  <= HP_COEF_CH1_RST;
            cfg_reg.hp_coef[2]  <= HP_COEF_CH2_RST;
            cfg_reg.gain[0]     <= GAIN_CH0_RST;
            cfg_reg.gain[1]     <= GAIN_CH1_RST;
            cfg_reg.gain[2]     <= GAIN_CH2_RST;
            cfg_reg.plot_height <= PLOT_HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    bsfc_front #(
        .NCH (NCH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .plot_height (cfg_reg.plot_height),
        .q_stat      (q_stat),
        .push        (push),
        .push_item   (push_item)
    );

    bsfc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .pop_item  (pop_item),
        .q_stat    (q_stat)
    );

    bsfc_back #(
        .NCH        (NCH),
        .AVG_DEPTH  (AVG_DEPTH),
        .AVG_TAPS   (AVG_TAPS),
        .PLOT_DEPTH (PLOT_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_stat    (q_stat),
        .pop_item  (pop_item),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
